>>> rtl/core/fpp_pkg.sv
// ----------------------------------------------------------------------------
// Fixed partition placement package
// Shared types, sizes and codes for the partition placement block.
// ----------------------------------------------------------------------------
package fpp_pkg;

    localparam int NUM_BLOCKS  = 5;
    localparam int SIZE_REGS   = 5;
    localparam int IDX_W       = 3;
    localparam int SIZE_W      = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [SIZE_W-1:0] DEFAULT_CAP = 16'd300;

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    localparam logic [1:0] STRAT_FIRST = 2'd0;
    localparam logic [1:0] STRAT_BEST  = 2'd1;
    localparam logic [1:0] STRAT_WORST = 2'd2;
    localparam logic [1:0] STRAT_NEXT  = 2'd3;

    localparam logic [1:0] STATUS_ALLOC   = 2'd0;
    localparam logic [1:0] STATUS_NOFIT   = 2'd1;
    localparam logic [1:0] STATUS_RESTART = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_STRATEGY = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE0    = 3'd1;

    typedef struct packed {
        logic              op;
        logic [SIZE_W-1:0] request_size;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [IDX_W-1:0] block_index;
    } out_beat_t;

endpackage

>>> rtl/core/fixed_partition_placement.sv
// ----------------------------------------------------------------------------
// Fixed partition placement
// Picks a partition for each allocate beat by first, best, worst or next fit
// and tracks the used amount and full flag of every partition.
// ----------------------------------------------------------------------------
//  Channel   Ports                          Direction  Payload
//  s_        s_valid, s_ready, s_data       in         op, request_size
//  m_        m_valid, m_ready, m_data       out        status, block_index
//  cfg_      cfg_wr_en, cfg_index, cfg_wdata in        strategy, block sizes
//
// An allocate beat passes from idle through a scan, an update when a partition
// was chosen, and a finish state that hands the result to the output register:
// one shared subtract and compare unit visits one partition per cycle. A restart beat goes from idle to finish.
// Reset is synchronous and active low; sizes return to 300, allocations clear.
// The block takes a new beat only when idle, and holds a finished result in
// its output register while m_ready is low.
module fixed_partition_placement (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  fpp_pkg::in_beat_t                s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output fpp_pkg::out_beat_t               m_data,
    input  logic                             cfg_wr_en,
    input  logic [fpp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [fpp_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import fpp_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_UPDATE = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0]        state_reg;
    logic [1:0]        strategy_reg;
    logic [SIZE_W-1:0] size_reg [SIZE_REGS];
    logic [SIZE_W-1:0] used_reg [NUM_BLOCKS];
    logic              full_reg [NUM_BLOCKS];
    logic [IDX_W-1:0]  next_start_reg;
    logic [IDX_W-1:0]  start_reg;
    logic [IDX_W-1:0]  step_reg;
    logic [SIZE_W-1:0] req_reg;
    logic              chosen_valid_reg;
    logic [IDX_W-1:0]  chosen_reg;
    logic [SIZE_W-1:0] best_reg;
    logic [SIZE_W-1:0] sum_reg;
    out_beat_t         result_reg;
    logic              m_valid_reg;
    out_beat_t         m_data_reg;

    logic [IDX_W:0]    pos_sum;
    logic [IDX_W-1:0]  scan_idx;
    logic [SIZE_W-1:0] cap;
    logic [SIZE_W+1:0] leftover;
    logic              fits;
    logic              take;
    logic              stop_early;
    logic              last_step;
    logic [IDX_W-1:0]  cfg_size_idx;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign pos_sum  = {1'b0, start_reg} + {1'b0, step_reg};
    assign scan_idx = (pos_sum >= (IDX_W+1)'(NUM_BLOCKS))
                    ? IDX_W'(pos_sum - (IDX_W+1)'(NUM_BLOCKS)) : pos_sum[IDX_W-1:0];

    always_comb begin
        if (scan_idx < IDX_W'(SIZE_REGS)) begin
            cap = size_reg[scan_idx];
        end else begin
            cap = DEFAULT_CAP;
        end
    end

    assign leftover = {2'b00, cap} - {2'b00, used_reg[scan_idx]} - {2'b00, req_reg};
    assign fits     = !full_reg[scan_idx] && !leftover[SIZE_W+1];
    assign take     = fits && (!chosen_valid_reg
                    || (strategy_reg == STRAT_BEST  && leftover[SIZE_W-1:0] < best_reg)
                    || (strategy_reg == STRAT_WORST && leftover[SIZE_W-1:0] > best_reg));
    assign stop_early = fits && (strategy_reg == STRAT_FIRST || strategy_reg == STRAT_NEXT);
    assign last_step  = (step_reg == IDX_W'(NUM_BLOCKS - 1));
    assign cfg_size_idx = cfg_index - REG_SIZE0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            strategy_reg <= STRAT_FIRST;
            for (int i = 0; i < SIZE_REGS; i++) begin
                size_reg[i] <= DEFAULT_CAP;
            end
        end else if (cfg_wr_en) begin
            if (cfg_index == REG_STRATEGY) begin
                strategy_reg <= cfg_wdata[1:0];
            end else if (cfg_index >= REG_SIZE0
                         && cfg_index < REG_SIZE0 + CFG_IDX_W'(SIZE_REGS)) begin
                size_reg[cfg_size_idx] <= cfg_wdata[SIZE_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            next_start_reg   <= '0;
            chosen_valid_reg <= 1'b0;
            m_valid_reg      <= 1'b0;
            for (int i = 0; i < NUM_BLOCKS; i++) begin
                used_reg[i] <= '0;
                full_reg[i] <= 1'b0;
            end
        end else begin
            if (m_valid_reg && m_ready && state_reg != S_FINISH) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        req_reg          <= s_data.request_size;
                        step_reg         <= '0;
                        chosen_valid_reg <= 1'b0;
                        if (strategy_reg == STRAT_NEXT
                            && next_start_reg < IDX_W'(NUM_BLOCKS)) begin
                            start_reg <= next_start_reg;
                        end else begin
                            start_reg <= '0;
                        end
                        if (s_data.op == OP_RESTART) begin
                            for (int i = 0; i < NUM_BLOCKS; i++) begin
                                used_reg[i] <= '0;
                                full_reg[i] <= 1'b0;
                            end
                            next_start_reg         <= '0;
                            result_reg.status      <= STATUS_RESTART;
                            result_reg.block_index <= '0;
                            state_reg              <= S_FINISH;
                        end else begin
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    step_reg <= step_reg + 1'b1;
                    if (take) begin
                        chosen_valid_reg <= 1'b1;
                        chosen_reg       <= scan_idx;
                        best_reg         <= leftover[SIZE_W-1:0];
                        sum_reg          <= used_reg[scan_idx] + req_reg;
                    end
                    if (stop_early || last_step) begin
                        if (take || chosen_valid_reg) begin
                            state_reg <= S_UPDATE;
                        end else begin
                            result_reg.status      <= STATUS_NOFIT;
                            result_reg.block_index <= '0;
                            state_reg              <= S_FINISH;
                        end
                    end
                end
                S_UPDATE: begin
                    used_reg[chosen_reg] <= sum_reg;
                    if (best_reg == '0) begin
                        full_reg[chosen_reg] <= 1'b1;
                    end
                    if (strategy_reg == STRAT_NEXT) begin
                        if (chosen_reg == IDX_W'(NUM_BLOCKS - 1)) begin
                            next_start_reg <= '0;
                        end else begin
                            next_start_reg <= chosen_reg + 1'b1;
                        end
                    end
                    result_reg.status      <= STATUS_ALLOC;
                    result_reg.block_index <= chosen_reg;
                    state_reg              <= S_FINISH;
                end
                S_FINISH: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= result_reg;
                        state_reg   <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("block accepted a beat and stayed ready");

    a_update_has_choice: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_UPDATE) |-> (chosen_valid_reg && chosen_reg < IDX_W'(NUM_BLOCKS)))
        else $error("update without a chosen partition");

    a_next_start_range: assert property (@(posedge aclk) disable iff (!aresetn)
        next_start_reg < IDX_W'(NUM_BLOCKS))
        else $error("next fit pointer out of range");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.status == STATUS_ALLOC || m_data.status == STATUS_NOFIT
                     || m_data.status == STATUS_RESTART))
        else $error("illegal status code");

    a_index_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status != STATUS_ALLOC) |-> (m_data.block_index == '0))
        else $error("nonzero index without an allocation");
`endif

endmodule

>>> tb/fixed_partition_placement_test.sv
// ----------------------------------------------------------------------------
// Fixed partition placement testbench
// Drives allocate and restart beats under all four fit strategies and a range
// of partition sizes, predicts every placement with its own model of the used
// amounts, full flags and next-fit pointer, and checks each result beat.
// ----------------------------------------------------------------------------
module fixed_partition_placement_test;
    import fpp_pkg::*;

    localparam int IDLE_LIMIT    = 5000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 12;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_BEATS   = 62;

    class placement_checker;
        logic [1:0]        strategy;
        logic [SIZE_W-1:0] capacity [NUM_BLOCKS];
        logic [SIZE_W-1:0] used [NUM_BLOCKS];
        bit                full [NUM_BLOCKS];
        int                next_start;
        out_beat_t         awaited_placements [$];
        int                mismatches;

        function new();
            strategy = STRAT_FIRST;
            foreach (capacity[i]) capacity[i] = DEFAULT_CAP;
            clear_partitions();
            mismatches = 0;
        endfunction

        function void clear_partitions();
            foreach (used[i]) begin
                used[i] = '0;
                full[i] = 1'b0;
            end
            next_start = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] index,
                                   logic [CFG_DATA_W-1:0] value);
            if (index == REG_STRATEGY) begin
                strategy = value[1:0];
            end else if (index >= REG_SIZE0 && index < REG_SIZE0 + SIZE_REGS) begin
                capacity[index - REG_SIZE0] = value[SIZE_W-1:0];
            end
        endfunction

        function int free_space(int slot);
            return int'(capacity[slot]) - int'(used[slot]);
        endfunction

        function bit fits(int slot, int need);
            return !full[slot] && free_space(slot) >= need;
        endfunction

        function out_beat_t choose_partition(in_beat_t beat);
            out_beat_t result;
            int        need;
            int        pick;
            int        margin;
            int        slot;
            result.status      = STATUS_ALLOC;
            result.block_index = '0;
            if (beat.op == OP_RESTART) begin
                clear_partitions();
                result.status = STATUS_RESTART;
                return result;
            end
            need   = int'(beat.request_size);
            pick   = -1;
            margin = 0;
            if (strategy == STRAT_NEXT) begin
                for (int k = 0; k < NUM_BLOCKS; k++) begin
                    slot = (next_start + k) % NUM_BLOCKS;
                    if (fits(slot, need)) begin
                        pick = slot;
                        break;
                    end
                end
            end else begin
                for (int i = 0; i < NUM_BLOCKS; i++) begin
                    if (!fits(i, need))
                        continue;
                    if (pick < 0 ||
                        (strategy == STRAT_BEST && free_space(i) - need < margin) ||
                        (strategy == STRAT_WORST && free_space(i) - need > margin)) begin
                        pick   = i;
                        margin = free_space(i) - need;
                    end
                    if (strategy == STRAT_FIRST)
                        break;
                end
            end
            if (pick < 0) begin
                result.status = STATUS_NOFIT;
                return result;
            end
            used[pick] = used[pick] + beat.request_size;
            if (used[pick] == capacity[pick])
                full[pick] = 1'b1;
            if (strategy == STRAT_NEXT)
                next_start = (pick + 1) % NUM_BLOCKS;
            result.block_index = IDX_W'(pick);
            return result;
        endfunction

        function void note_request(in_beat_t beat);
            awaited_placements.insert(awaited_placements.size(), choose_partition(beat));
        endfunction

        function void check_placement(out_beat_t got);
            out_beat_t want;
            if (awaited_placements.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result beat status %0d index %0d with none expected",
                             got.status, got.block_index);
                return;
            end
            want = awaited_placements.pop_front();
            if (got.status !== want.status || got.block_index !== want.block_index) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: expected status %0d index %0d, got status %0d index %0d",
                             want.status, want.block_index, got.status, got.block_index);
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    in_beat_t              s_data;
    logic                  m_valid;
    logic                  m_ready;
    out_beat_t             m_data;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    placement_checker board;
    int gap_pct       = 0;
    int stall_pct     = 0;
    int hold_requests = 0;
    int holds_done    = 0;
    int idle_cycles   = 0;

    fixed_partition_placement dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                board.note_request(s_data);
            if (m_valid && m_ready)
                board.check_placement(m_data);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // A pending hold request keeps m_ready low for a long stretch so the
    // block backs up and stalls its input.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (holds_done != hold_requests) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                holds_done++;
            end
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic offer(input logic op, input logic [SIZE_W-1:0] amount);
        in_beat_t beat;
        beat.op           = op;
        beat.request_size = amount;
        if ($urandom_range(99) < gap_pct) begin
            s_valid <= 1'b0;
            do @(negedge aclk); while ($urandom_range(99) < gap_pct);
        end
        s_valid <= 1'b1;
        s_data  <= beat;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic alloc(input int amount);
        offer(OP_ALLOC, SIZE_W'(amount));
    endtask

    task automatic restart();
        offer(OP_RESTART, SIZE_W'($urandom));
    endtask

    task automatic await_results();
        s_valid <= 1'b0;
        while (board.awaited_placements.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic set_register(input logic [CFG_IDX_W-1:0] index, input int value);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= CFG_DATA_W'(value);
        @(posedge aclk);
        board.set_register(index, CFG_DATA_W'(value));
        @(negedge aclk);
    endtask

    task automatic configure(input logic [1:0] mode, input int sizes [NUM_BLOCKS]);
        await_results();
        set_register(REG_STRATEGY, int'(mode));
        for (int i = 0; i < NUM_BLOCKS; i++)
            set_register(CFG_IDX_W'(REG_SIZE0 + i), sizes[i]);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        int         sizes [NUM_BLOCKS];
        logic [1:0] strategy_order [4];
        int         roll;
        int         pick;
        board     = new();
        s_valid   = 1'b0;
        s_data    = '0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        aresetn   = 1'b0;
        strategy_order = '{STRAT_FIRST, STRAT_BEST, STRAT_WORST, STRAT_NEXT};
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        alloc(0);
        alloc(300);
        alloc(0);
        alloc(65535);
        alloc(301);
        restart();

        sizes = '{0, 65535, 100, 50, 100};
        configure(STRAT_BEST, sizes);
        alloc(0);
        alloc(50);
        alloc(50);
        alloc(50);
        alloc(65535);

        sizes = '{200, 200, 200, 100, 100};
        configure(STRAT_WORST, sizes);
        alloc(10);
        restart();
        alloc(10);
        alloc(10);

        // Partition 0 now holds more than its new capacity.
        sizes = '{5, 200, 200, 100, 100};
        configure(STRAT_WORST, sizes);
        alloc(0);

        sizes = '{300, 300, 300, 300, 300};
        configure(STRAT_NEXT, sizes);
        restart();
        alloc(100);
        alloc(250);
        alloc(300);
        alloc(300);
        alloc(300);
        alloc(100);
        alloc(100);

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            for (int i = 0; i < NUM_BLOCKS; i++) begin
                case ($urandom_range(9))
                    0: sizes[i] = 0;
                    1: sizes[i] = 65535;
                    2: sizes[i] = $urandom_range(65535);
                    default: sizes[i] = $urandom_range(20, 400);
                endcase
            end
            configure(strategy_order[phase % 4], sizes);
            case ((phase / 3) % 4)
                0: begin
                    gap_pct   = 0;
                    stall_pct = 0;
                end
                1: begin
                    gap_pct   = 61;
                    stall_pct = 0;
                end
                2: begin
                    gap_pct   = 0;
                    stall_pct = 61;
                end
                default: begin
                    gap_pct   = 33;
                    stall_pct = 33;
                end
            endcase
            for (int n = 0; n < PHASE_BEATS; n++) begin
                if (phase == 1 && n == 10)
                    hold_requests++;
                if (n == PHASE_BEATS / 2)
                    await_results();
                roll = $urandom_range(99);
                pick = $urandom_range(NUM_BLOCKS - 1);
                if (roll < 6)
                    restart();
                else if (roll < 14)
                    alloc($urandom_range(65535));
                else if (roll < 20)
                    alloc(0);
                else if (roll < 23)
                    alloc(65535);
                else if (roll < 45)
                    alloc(board.free_space(pick) > 0 ? board.free_space(pick) : 1);
                else
                    alloc($urandom_range(1, 120));
            end
        end

        await_results();
        if (board.mismatches == 0 && board.awaited_placements.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

>>> filelist.f
rtl/core/fpp_pkg.sv
rtl/core/fixed_partition_placement.sv
tb/fixed_partition_placement_test.sv
